@@ sv/esl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// esl_pkg: types, codes and constants for the event-stream line parser
// no dependencies; imported by esl_step, esl_rsp_reg and event_stream_line_parser

package esl_pkg;

   localparam int SPACE_COUNT_MAX = 255;
   localparam int SPACE_LIMIT_INT = (SPACE_COUNT_MAX > 255) ? 255 : SPACE_COUNT_MAX;
   localparam logic [7:0] SPACE_LIMIT = 8'(SPACE_LIMIT_INT);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [7:0] CHAR_COLON   = 8'h3a;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_E       = 8'h65;
   localparam logic [7:0] CHAR_D       = 8'h64;

   localparam int EVENT_LEN = 5;
   localparam int DATA_LEN  = 4;

   // line phase codes
   localparam logic [1:0] PH_START   = 2'd0;
   localparam logic [1:0] PH_NAME    = 2'd1;
   localparam logic [1:0] PH_VALUE   = 2'd2;
   localparam logic [1:0] PH_COMMENT = 2'd3;

   // field roles
   localparam logic [1:0] ROLE_NONE  = 2'd0;
   localparam logic [1:0] ROLE_EVENT = 2'd1;
   localparam logic [1:0] ROLE_DATA  = 2'd2;

   // result kinds
   localparam logic [2:0] K_DATA     = 3'd0;
   localparam logic [2:0] K_EVT      = 3'd1;
   localparam logic [2:0] K_SEP      = 3'd2;
   localparam logic [2:0] K_NEWEVT   = 3'd3;
   localparam logic [2:0] K_DISPATCH = 3'd4;
   localparam logic [2:0] K_DISCARD  = 3'd5;

   typedef struct packed {
      logic       hit;
      logic [2:0] kind;
      logic [7:0] data;
      logic [7:0] spaces;
   } rsp_type;

   function automatic logic [7:0] event_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h65; // e
         3'd1:    c = 8'h76; // v
         3'd2:    c = 8'h65; // e
         3'd3:    c = 8'h6e; // n
         3'd4:    c = 8'h74; // t
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] data_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h64; // d
         2'd1:    c = 8'h61; // a
         2'd2:    c = 8'h74; // t
         2'd3:    c = 8'h61; // a
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/esl_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// esl_step: parser state registers and the per-byte update logic
// depends on esl_pkg

module esl_step (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step_en,
   input  wire logic [7:0]      step_byte,
   output esl_pkg::rsp_type     step_rsp
);
   import esl_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [2:0] match_ff, match_in;
   logic [1:0] role_ff, role_in;
   logic       started_ff, started_in;
   logic [7:0] pending_ff, pending_in;
   logic       seen_ff, seen_in;

   // name byte outcome
   logic [1:0] nb_phase, nb_role;
   logic [2:0] nb_match;

   // name end outcome
   logic       ne_hit, ne_set_seen;
   logic [2:0] ne_kind;
   logic [1:0] ne_role;

   rsp_type rsp;

   always_comb begin
      nb_phase = phase_ff;
      nb_role  = role_ff;
      nb_match = match_ff;
      if (match_ff == 3'd0 && role_ff == ROLE_NONE && phase_ff == PH_START) begin
         nb_phase = PH_NAME;
         if (step_byte == CHAR_E) begin
            nb_role  = ROLE_EVENT;
            nb_match = 3'd1;
         end else if (step_byte == CHAR_D) begin
            nb_role  = ROLE_DATA;
            nb_match = 3'd1;
         end else begin
            nb_role  = ROLE_NONE;
            nb_match = 3'd0;
         end
      end else if (role_ff == ROLE_EVENT && match_ff < 3'(EVENT_LEN)
                   && step_byte == event_char(match_ff)) begin
         nb_match = match_ff + 3'd1;
      end else if (role_ff == ROLE_DATA && match_ff < 3'(DATA_LEN)
                   && step_byte == data_char(match_ff[1:0])) begin
         nb_match = match_ff + 3'd1;
      end else begin
         nb_role  = ROLE_NONE;
         nb_match = 3'd0;
      end
   end

   always_comb begin
      ne_hit      = 1'b0;
      ne_kind     = K_NEWEVT;
      ne_set_seen = 1'b0;
      ne_role     = role_ff;
      if (role_ff == ROLE_EVENT && match_ff == 3'(EVENT_LEN)) begin
         ne_hit = 1'b1;
      end else if (role_ff == ROLE_DATA && match_ff == 3'(DATA_LEN)) begin
         if (seen_ff) begin
            ne_hit  = 1'b1;
            ne_kind = K_SEP;
         end else begin
            ne_set_seen = 1'b1;
         end
      end else begin
         ne_role = ROLE_NONE;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      match_in   = match_ff;
      role_in    = role_ff;
      started_in = started_ff;
      pending_in = pending_ff;
      seen_in    = seen_ff;
      rsp        = '0;
      case (phase_ff)
         PH_START: begin
            if (step_byte == CHAR_NEWLINE) begin
               rsp.hit  = 1'b1;
               rsp.kind = seen_ff ? K_DISPATCH : K_DISCARD;
               seen_in  = 1'b0;
            end else if (step_byte == CHAR_COLON) begin
               phase_in = PH_COMMENT;
            end else begin
               phase_in = nb_phase;
               role_in  = nb_role;
               match_in = nb_match;
            end
         end
         PH_NAME: begin
            if (step_byte == CHAR_NEWLINE || step_byte == CHAR_COLON) begin
               rsp.hit  = ne_hit;
               rsp.kind = ne_kind;
               if (ne_set_seen) begin
                  seen_in = 1'b1;
               end
               if (step_byte == CHAR_NEWLINE) begin
                  phase_in   = PH_START;
                  match_in   = 3'd0;
                  role_in    = ROLE_NONE;
                  started_in = 1'b0;
                  pending_in = 8'd0;
               end else begin
                  phase_in   = PH_VALUE;
                  role_in    = ne_role;
                  started_in = 1'b0;
                  pending_in = 8'd0;
               end
            end else begin
               phase_in = nb_phase;
               role_in  = nb_role;
               match_in = nb_match;
            end
         end
         PH_VALUE: begin
            if (step_byte == CHAR_NEWLINE) begin
               phase_in   = PH_START;
               match_in   = 3'd0;
               role_in    = ROLE_NONE;
               started_in = 1'b0;
               pending_in = 8'd0;
            end else if (role_ff == ROLE_NONE) begin
               phase_in = phase_ff;
            end else if (step_byte == CHAR_SPACE) begin
               if (started_ff && pending_ff < SPACE_LIMIT) begin
                  pending_in = pending_ff + 8'd1;
               end
            end else begin
               rsp.hit    = 1'b1;
               rsp.kind   = (role_ff == ROLE_DATA) ? K_DATA : K_EVT;
               rsp.data   = step_byte;
               rsp.spaces = pending_ff;
               pending_in = 8'd0;
               started_in = 1'b1;
            end
         end
         default: begin
            if (step_byte == CHAR_NEWLINE) begin
               phase_in   = PH_START;
               match_in   = 3'd0;
               role_in    = ROLE_NONE;
               started_in = 1'b0;
               pending_in = 8'd0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         match_ff   <= 3'd0;
         role_ff    <= ROLE_NONE;
         started_ff <= 1'b0;
         pending_ff <= 8'd0;
         seen_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         match_ff   <= match_in;
         role_ff    <= role_in;
         started_ff <= started_in;
         pending_ff <= pending_in;
         seen_ff    <= seen_in;
      end
   end

   assign step_rsp = rsp;

endmodule

`default_nettype wire

@@ sv/esl_rsp_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// esl_rsp_reg: result register on the response channel
// depends on esl_pkg

module esl_rsp_reg (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            load,
   input  esl_pkg::rsp_type     load_rsp,
   output logic                 free,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [2:0]           rsp_out_kind,
   output logic [7:0]           rsp_out_byte,
   output logic [7:0]           rsp_spaces_before
);
   import esl_pkg::*;

   logic       valid_ff, valid_in;
   rsp_type    data_ff;

   // room when empty or being taken this cycle
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && rsp_stall) begin
         valid_in = 1'b1;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_rsp;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_kind      = data_ff.kind;
   assign rsp_out_byte      = data_ff.data;
   assign rsp_spaces_before = data_ff.spaces;

endmodule

`default_nettype wire

@@ sv/event_stream_line_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// event_stream_line_parser: top level of the event-stream line parser
// depends on esl_pkg, esl_step and esl_rsp_reg
//
//   channel   ports                                               direction
//   req       req_valid req_stall req_in_byte                     in  (one byte per item)
//   rsp       rsp_valid rsp_stall rsp_out_kind rsp_out_byte       out (zero or one item
//             rsp_spaces_before                                        per byte)
//
// one byte per cycle while rsp does not stall; a byte passes the input register, then the result register
// the per-byte update is a single pass of compare and select logic on the parser state
// reset (synchronous, active high) empties both registers and puts the parser at line start
// a stall on rsp holds the result register; the input register then holds too and req stalls
// bytes that give no result still need a free result register to advance

module event_stream_line_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_out_kind,
   output logic [7:0]       rsp_out_byte,
   output logic [7:0]       rsp_spaces_before
);
   import esl_pkg::*;

   // input register
   logic       req_valid_ff, req_valid_in;
   logic [7:0] req_byte_ff;

   logic       out_free;
   logic       advance;
   rsp_type    step_rsp;

   // the held byte moves through the parser when the result register has room
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !advance;

   always_comb begin
      if (!req_stall) begin
         req_valid_in = req_valid;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_byte_ff <= req_in_byte;
      end
   end

   // parser state and per-byte logic
   esl_step u_step (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_byte (req_byte_ff),
      .step_rsp  (step_rsp)
   );

   // result register, loaded only when the byte produces an item
   esl_rsp_reg u_rsp_reg (
      .clock             (clock),
      .reset             (reset),
      .load              (advance && step_rsp.hit),
      .load_rsp          (step_rsp),
      .free              (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_spaces_before (rsp_spaces_before)
   );

endmodule

`default_nettype wire
